FILE: rtl/cfiir_pkg.sv
// Shared constants for the cascaded fourth-order IIR filter.
// Used by the channel interfaces, the top level and the port checker.
`timescale 1ns / 1ps

package cfiir_pkg;

  localparam int STAGES_DEF   = 4;
  localparam int SAMPLE_W_DEF = 24;

  localparam int COEF_W      = 32;  // Q5.27 coefficients and gain
  localparam int DW_W        = 40;  // Q9.31 delay words and stage signals
  localparam int ACC_W       = 48;  // accumulator for the sums of five products
  localparam int TAPS        = 4;   // delay words per stage
  localparam int NCOEF       = 9;   // coefficients per stage
  localparam int STAGE_SEL_W = 2;
  localparam int COEF_SEL_W  = 4;

  // Coefficient slots: a1..a4 live at 0..3, b0 at 4, b1..b4 at 5..8.
  localparam int SLOT_B0 = 4;
  localparam int SLOT_B1 = 5;

  // A 32 x 40 product is built from two 32 x 24 passes.
  localparam int LO_W    = 16;
  localparam int HALF_W  = DW_W - LO_W;
  localparam int MUL_W   = COEF_W + HALF_W;
  localparam int FULL_W  = COEF_W + DW_W;
  localparam int FRAC_SH = 27;
  localparam int PROD_W  = FULL_W - FRAC_SH;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic signed [COEF_W-1:0] GAIN_RESET = 32'sd134217728;

endpackage

FILE: rtl/cfiir_if.sv
// Valid/ready channel interfaces for the cascaded IIR filter.
// Depends on cfiir_pkg for field widths.
`timescale 1ns / 1ps

interface cfiir_in_if #(
  parameter int SAMPLE_WIDTH = cfiir_pkg::SAMPLE_W_DEF
);
  logic                                      valid;
  logic                                      ready;
  logic                                      mode;
  logic signed [SAMPLE_WIDTH-1:0]            sample_in;
  logic [cfiir_pkg::STAGE_SEL_W-1:0]         stage_select;
  logic [cfiir_pkg::COEF_SEL_W-1:0]          coeff_select;
  logic signed [cfiir_pkg::COEF_W-1:0]       coeff_value;

  modport source (output valid, mode, sample_in, stage_select, coeff_select, coeff_value,
                  input ready);
  modport sink (input valid, mode, sample_in, stage_select, coeff_select, coeff_value,
                output ready);
endinterface

interface cfiir_out_if #(
  parameter int SAMPLE_WIDTH = cfiir_pkg::SAMPLE_W_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink (input valid, sample_out, clipped, output ready);
endinterface

FILE: rtl/cascaded_fourth_order_iir_top.sv
// Cascade of fourth-order direct-form-II IIR sections with output gain.
// Depends on cfiir_pkg and the channel interfaces in cfiir_if.sv.
//
//   channel  dir  transaction content
//   in_ch    in   mode, sample_in, stage_select, coeff_select, coeff_value
//   out_ch   out  sample_out, clipped (one per audio sample transaction)
//   cfg_*    in   output_gain write (cfg_we, cfg_wdata)
//
// A coefficient write completes in the cycle it is accepted and produces nothing.
// An audio sample is worked through each stage on the one shared multiplier (nine
// products, each in two 32 x 24 passes, then pipeline drain and a write-back),
// then through the gain and saturation. No new item is accepted until the result
// is registered for output, so one sample is in flight at a time. A waiting
// result does not block the input. Reset is synchronous;
// it clears the state and the valid bits of both memories.
`timescale 1ns / 1ps

module cascaded_fourth_order_iir_top #(
  parameter int STAGES       = cfiir_pkg::STAGES_DEF,
  parameter int SAMPLE_WIDTH = cfiir_pkg::SAMPLE_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic signed [cfiir_pkg::COEF_W-1:0] cfg_wdata,
  cfiir_in_if.sink                           in_ch,
  cfiir_out_if.source                        out_ch
);
  import cfiir_pkg::*;

  localparam int DDEPTH     = STAGES * TAPS;
  localparam int CDEPTH     = STAGES * NCOEF;
  localparam int DADDR_W    = $clog2(DDEPTH);
  localparam int CADDR_W    = $clog2(CDEPTH);
  localparam int STG_W      = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int SH         = 32 - SAMPLE_WIDTH;
  localparam int ISSUE_N    = 2 * NCOEF;
  localparam int PIPE_LAT   = 3;
  localparam int STAGE_LAST = ISSUE_N + PIPE_LAT;
  localparam int GAIN_LAST  = 1 + PIPE_LAT;
  localparam int CYC_W      = $clog2(STAGE_LAST + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_GAIN, ST_DONE} state_t;
  typedef enum logic [1:0] {DS_MEM, DS_W, DS_X} dsel_t;

  typedef struct packed {
    logic       vld;
    logic       hi;
    logic       fb;
    logic       cgain;
    dsel_t      dsel;
    logic       shift;
    logic [1:0] k;
  } tag_t;

  state_t                    state_r;
  logic [CYC_W-1:0]          cyc_r;
  logic [STG_W-1:0]          stage_r;
  logic signed [COEF_W-1:0]  gain_r;
  logic signed [DW_W-1:0]    x_r;
  logic signed [ACC_W-1:0]   fbacc_r;
  logic signed [ACC_W-1:0]   ffacc_r;
  logic                      clip_r;
  logic signed [DW_W-1:0]    w_r;
  logic                      w_clip_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                      out_clip_r;

  // Memories and their valid bits.
  logic signed [COEF_W-1:0]  cmem [0:CDEPTH-1];
  logic [CDEPTH-1:0]         cvld_r;
  logic signed [DW_W-1:0]    dmem [0:DDEPTH-1];
  logic [DDEPTH-1:0]         dvld_r;
  logic signed [COEF_W-1:0]  coef_rd_r;
  logic                      coef_vld_r;
  logic signed [DW_W-1:0]    dly_rd_r;
  logic                      dly_vld_r;

  // Multiplier pipeline.
  tag_t                      p1_r, p2_r, p3_r, tag_nxt;
  logic signed [MUL_W-1:0]   m_r, lo_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      in_acc;
  logic                      coef_we;
  logic [CADDR_W-1:0]        coef_waddr;
  logic [CADDR_W-1:0]        caddr;
  logic [DADDR_W-1:0]        daddr;
  logic [3:0]                slot;
  logic [CYC_W-2:0]          j;
  logic signed [DW_W-1:0]    x_in;
  logic signed [COEF_W-1:0]  c_op;
  logic signed [DW_W-1:0]    dmem_q, d_op;
  logic signed [HALF_W-1:0]  half;
  logic signed [MUL_W-1:0]   m;
  logic signed [FULL_W-1:0]  full;
  logic                      dwe;
  logic [DADDR_W-1:0]        dwaddr;
  logic signed [DW_W-1:0]    dwdata;
  logic signed [DW_W-1:0]    wsat, ysat;
  logic                      wclip, yclip;
  logic signed [ACC_W-1:0]   oshift;
  logic signed [SAMPLE_WIDTH-1:0] osat;
  logic                      oclip;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clip_r;

  assign x_in = DW_W'(in_ch.sample_in) <<< SH;

  assign coef_we = in_acc && (in_ch.mode == MODE_COEF) &&
                   (int'(in_ch.stage_select) < STAGES) &&
                   (int'(in_ch.coeff_select) < NCOEF);
  assign coef_waddr = CADDR_W'(int'(in_ch.stage_select) * NCOEF + int'(in_ch.coeff_select));

  // Issue decode: product j of the stage, two passes per product.
  // Feedforward taps are read from z4 down to z1 so that each shifted delay
  // word can be written one slot up right after its last read.
  always_comb begin
    j       = cyc_r[CYC_W-1:1];
    tag_nxt = '0;
    slot    = 4'(SLOT_B0);
    tag_nxt.hi = cyc_r[0];
    if (j < (CYC_W-1)'(TAPS)) begin
      tag_nxt.fb = 1'b1;
      tag_nxt.k  = j[1:0];
      slot       = 4'(j);
      tag_nxt.dsel = DS_MEM;
    end else if (j < (CYC_W-1)'(2 * TAPS)) begin
      tag_nxt.k     = ~j[1:0];
      slot          = 4'(SLOT_B1) + 4'(tag_nxt.k);
      tag_nxt.dsel  = DS_MEM;
      tag_nxt.shift = (tag_nxt.k != 2'(TAPS - 1));
    end else begin
      tag_nxt.dsel = DS_W;
    end
    if (state_r == ST_GAIN) begin
      tag_nxt     = '0;
      tag_nxt.hi  = cyc_r[0];
      tag_nxt.cgain = 1'b1;
      tag_nxt.dsel  = DS_X;
      tag_nxt.vld = (cyc_r < CYC_W'(2));
    end else begin
      tag_nxt.vld = (state_r == ST_RUN) && (cyc_r < CYC_W'(ISSUE_N));
    end
  end

  assign caddr = CADDR_W'(int'(stage_r) * NCOEF + int'(slot));
  assign daddr = DADDR_W'(int'(stage_r) * TAPS + int'(tag_nxt.k));

  // Operand select and first multiplier pass.
  always_comb begin
    c_op   = p1_r.cgain ? gain_r : (coef_vld_r ? coef_rd_r : '0);
    dmem_q = dly_vld_r ? dly_rd_r : '0;
    unique case (p1_r.dsel)
      DS_W:    d_op = w_r;
      DS_X:    d_op = x_r;
      default: d_op = dmem_q;
    endcase
    half = p1_r.hi ? d_op[DW_W-1:LO_W] : HALF_W'({1'b0, d_op[LO_W-1:0]});
  end

  assign m    = c_op * half;
  assign full = (FULL_W'(m_r) <<< LO_W) + FULL_W'(lo_r);

  // Delay write port: shifted taps during the stage, the new word at its end.
  always_comb begin
    dwe    = 1'b0;
    dwaddr = DADDR_W'(int'(stage_r) * TAPS);
    dwdata = w_r;
    if (p1_r.vld && p1_r.shift && p1_r.hi) begin
      dwe    = 1'b1;
      dwaddr = DADDR_W'(int'(stage_r) * TAPS + int'(p1_r.k) + 1);
      dwdata = dmem_q;
    end else if (state_r == ST_RUN && cyc_r == CYC_W'(STAGE_LAST)) begin
      dwe = 1'b1;
    end
  end

  // Saturation of the stage signals and of the output sample.
  always_comb begin
    wclip = !(fbacc_r[ACC_W-1:DW_W-1] == '0 || fbacc_r[ACC_W-1:DW_W-1] == '1);
    wsat  = fbacc_r[DW_W-1:0];
    if (wclip) wsat = fbacc_r[ACC_W-1] ? {1'b1, {(DW_W-1){1'b0}}} : {1'b0, {(DW_W-1){1'b1}}};
    yclip = !(ffacc_r[ACC_W-1:DW_W-1] == '0 || ffacc_r[ACC_W-1:DW_W-1] == '1);
    ysat  = ffacc_r[DW_W-1:0];
    if (yclip) ysat = ffacc_r[ACC_W-1] ? {1'b1, {(DW_W-1){1'b0}}} : {1'b0, {(DW_W-1){1'b1}}};
    oshift = ffacc_r >>> SH;
    oclip  = !(oshift[ACC_W-1:SAMPLE_WIDTH-1] == '0 || oshift[ACC_W-1:SAMPLE_WIDTH-1] == '1);
    osat   = oshift[SAMPLE_WIDTH-1:0];
    if (oclip) begin
      osat = oshift[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (coef_we) cmem[coef_waddr] <= in_ch.coeff_value;
    coef_rd_r <= cmem[caddr];
  end

  // Delay memory.
  always_ff @(posedge clk) begin
    if (dwe) dmem[dwaddr] <= dwdata;
    dly_rd_r <= dmem[daddr];
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r     <= '0;
      dvld_r     <= '0;
      coef_vld_r <= 1'b0;
      dly_vld_r  <= 1'b0;
    end else begin
      if (coef_we) cvld_r[coef_waddr] <= 1'b1;
      if (dwe) dvld_r[dwaddr] <= 1'b1;
      coef_vld_r <= cvld_r[caddr];
      dly_vld_r  <= dvld_r[daddr];
    end
  end

  // Multiplier pipeline: pass, combine and floor, accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
      p3_r <= '0;
    end else begin
      p1_r     <= tag_nxt;
      p2_r     <= p1_r;
      p3_r     <= p2_r;
      p3_r.vld <= p2_r.vld && p2_r.hi;
    end
    m_r <= m;
    if (p2_r.vld && !p2_r.hi) lo_r <= m_r;
    if (p2_r.vld && p2_r.hi) prod_r <= full[FULL_W-1:FRAC_SH];
  end

  always_ff @(posedge clk) begin
    w_r      <= wsat;
    w_clip_r <= wclip;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (p3_r.vld) begin
        if (p3_r.fb) fbacc_r <= fbacc_r - ACC_W'(prod_r);
        else         ffacc_r <= ffacc_r + ACC_W'(prod_r);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.mode == MODE_SAMPLE) begin
            x_r     <= x_in;
            fbacc_r <= ACC_W'(x_in);
            ffacc_r <= '0;
            clip_r  <= 1'b0;
            stage_r <= '0;
            cyc_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          cyc_r <= cyc_r + 1'b1;
          if (cyc_r == CYC_W'(STAGE_LAST)) begin
            x_r     <= ysat;
            fbacc_r <= ACC_W'(ysat);
            ffacc_r <= '0;
            clip_r  <= clip_r | w_clip_r | yclip;
            cyc_r   <= '0;
            if (stage_r == STG_W'(STAGES - 1)) state_r <= ST_GAIN;
            else stage_r <= stage_r + 1'b1;
          end
        end
        ST_GAIN: begin
          cyc_r <= cyc_r + 1'b1;
          if (cyc_r == CYC_W'(GAIN_LAST)) begin
            cyc_r   <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_sample_r <= osat;
            out_clip_r   <= clip_r | oclip;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/cfiir_checker.sv
// Port-level assertions for the cascaded IIR filter, bound to its top level.
// Depends on cfiir_pkg and cascaded_fourth_order_iir_top.
`timescale 1ns / 1ps

module cfiir_checker #(
  parameter int SAMPLE_WIDTH = cfiir_pkg::SAMPLE_W_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_mode,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample,
  input logic                    out_clipped
);
  import cfiir_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_clipped))
    else $error("result changed while stalled");

  // A sample keeps the filter busy, so the input closes right after it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_SAMPLE |=> !in_ready)
    else $error("input open while a sample is in flight");

  // No result appears in the cycle after any input transaction.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cascaded_fourth_order_iir_top cfiir_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_clipped(out_ch.clipped)
);

FILE: tb/cascaded_fourth_order_iir_top_tb.sv
// Self-checking testbench for the cascaded fourth-order IIR filter top level.
// Depends on cfiir_pkg, the channel interfaces in cfiir_if.sv and the RTL top.
// A fixed-point model of the cascade predicts every output sample and checks it.
`timescale 1ns / 1ps

typedef struct {
  logic                                    mode;
  logic signed [cfiir_pkg::SAMPLE_W_DEF-1:0] sample;
  logic [cfiir_pkg::STAGE_SEL_W-1:0]       stage;
  logic [cfiir_pkg::COEF_SEL_W-1:0]        slot;
  logic signed [cfiir_pkg::COEF_W-1:0]     coeff;
} filter_txn_t;

typedef struct {
  logic signed [cfiir_pkg::SAMPLE_W_DEF-1:0] sample;
  logic                                    clipped;
} filter_result_t;

class cascade_scoreboard;
  localparam int     STAGES       = cfiir_pkg::STAGES_DEF;
  localparam int     SAMPLE_W     = cfiir_pkg::SAMPLE_W_DEF;
  // Samples are Q1.(W-1) and stage signals Q9.31, so widening is a left shift.
  localparam int     SAMPLE_SHIFT = 32 - SAMPLE_W;
  localparam longint DW_MAX       = (longint'(1) <<< (cfiir_pkg::DW_W - 1)) - 1;
  localparam longint DW_MIN       = -DW_MAX - 1;
  localparam longint SMP_MAX      = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SMP_MIN      = -SMP_MAX - 1;
  localparam int     MAX_REPORTS  = 100;

  longint                              delay_line [STAGES*cfiir_pkg::TAPS];
  logic signed [cfiir_pkg::COEF_W-1:0] coef_store [STAGES*cfiir_pkg::NCOEF];
  logic signed [cfiir_pkg::COEF_W-1:0] output_gain;
  filter_result_t                      expected_q [$];
  bit                                  saturated;
  int                                  mismatches;
  int                                  outputs_seen;
  int                                  clipped_seen;

  function new();
    foreach (delay_line[i]) delay_line[i] = 0;
    foreach (coef_store[i]) coef_store[i] = '0;
    output_gain  = cfiir_pkg::GAIN_RESET;
    mismatches   = 0;
    outputs_seen = 0;
    clipped_seen = 0;
  endfunction

  function void set_gain(logic signed [cfiir_pkg::COEF_W-1:0] g);
    output_gain = g;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Exact Q5.27 x Q9.31 product, floored back to Q9.31.
  function longint coef_product(logic signed [cfiir_pkg::COEF_W-1:0] c, longint d);
    logic signed [71:0] p;
    p = c * d;
    return longint'(p >>> cfiir_pkg::FRAC_SH);
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      saturated = 1'b1;
      return hi;
    end
    if (v < lo) begin
      saturated = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function void note_accepted(filter_txn_t t);
    longint         x;
    longint         acc;
    longint         w;
    longint         v;
    int             base;
    int             tap;
    filter_result_t r;
    if (t.mode == cfiir_pkg::MODE_COEF) begin
      if (t.slot < cfiir_pkg::NCOEF && t.stage < STAGES)
        coef_store[t.stage*cfiir_pkg::NCOEF + t.slot] = t.coeff;
      return;
    end
    saturated = 1'b0;
    x = longint'(t.sample) <<< SAMPLE_SHIFT;
    for (int s = 0; s < STAGES; s++) begin
      base = s * cfiir_pkg::NCOEF;
      tap  = s * cfiir_pkg::TAPS;
      acc  = x;
      for (int k = 0; k < cfiir_pkg::TAPS; k++)
        acc -= coef_product(coef_store[base+k], delay_line[tap+k]);
      w   = clamp(acc, DW_MIN, DW_MAX);
      acc = coef_product(coef_store[base+cfiir_pkg::SLOT_B0], w);
      for (int k = 0; k < cfiir_pkg::TAPS; k++)
        acc += coef_product(coef_store[base+cfiir_pkg::SLOT_B1+k], delay_line[tap+k]);
      for (int k = cfiir_pkg::TAPS - 1; k > 0; k--)
        delay_line[tap+k] = delay_line[tap+k-1];
      delay_line[tap] = w;
      x = clamp(acc, DW_MIN, DW_MAX);
    end
    v = coef_product(output_gain, x) >>> SAMPLE_SHIFT;
    v = clamp(v, SMP_MIN, SMP_MAX);
    r.sample  = v[SAMPLE_W-1:0];
    r.clipped = saturated;
    expected_q.push_back(r);
  endfunction

  function void check_output(logic signed [SAMPLE_W-1:0] got_sample, logic got_clip);
    filter_result_t e;
    outputs_seen++;
    if (got_clip === 1'b1) clipped_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("output transaction with no sample pending: sample_out=%0d clipped=%b",
               got_sample, got_clip);
      return;
    end
    e = expected_q.pop_front();
    if (got_sample !== e.sample) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("sample_out mismatch: expected %0d, actual %0d", e.sample, got_sample);
    end
    if (got_clip !== e.clipped) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("clipped mismatch: expected %b, actual %b", e.clipped, got_clip);
    end
  endfunction
endclass

module cascaded_fourth_order_iir_top_tb;

  localparam int STAGES       = cfiir_pkg::STAGES_DEF;
  localparam int SAMPLE_W     = cfiir_pkg::SAMPLE_W_DEF;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int LATENCY      = 22 * STAGES + 6;
  localparam int SETTLE       = LATENCY + 16;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int ITEM_TARGET  = 1550;
  localparam int MIN_PHASES   = 8;
  localparam int SLOT_A1      = 0;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q27  = 32'sh0800_0000;
  // Feedback taps below 0.24 each keep the sum of their magnitudes under one.
  localparam int A_GENTLE = 32212254;
  localparam int B_GENTLE = 80530637;

  typedef enum int {
    STYLE_GENTLE,
    STYLE_HOT_FEEDFORWARD,
    STYLE_WILD_FEEDBACK
  } coef_style_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic signed [cfiir_pkg::COEF_W-1:0] cfg_wdata;

  cfiir_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  cfiir_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

  cascaded_fourth_order_iir_top #(
    .STAGES      (STAGES),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  cascade_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_sent   = 0;
  int coef_writes    = 0;
  int gain_writes    = 0;

  int send_idle_tbl [4] = '{0, 86, 0, 28};
  int recv_stall_tbl [4] = '{0, 0, 86, 28};
  logic signed [31:0] gain_table [8] = '{32'sh0800_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                         32'sh0000_0000, 32'sh0400_0000, -32'sh0800_0000,
                                         32'sh0000_0000, 32'sh1800_0000};

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
             sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [31:0] rand_sym(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic filter_txn_t sample_txn(logic signed [SAMPLE_W-1:0] s);
    filter_txn_t t;
    logic [31:0] junk;
    junk     = $urandom;
    t.mode   = cfiir_pkg::MODE_SAMPLE;
    t.sample = s;
    t.stage  = junk[1:0];
    t.slot   = junk[7:4];
    t.coeff  = $urandom;
    return t;
  endfunction

  function automatic filter_txn_t coeff_txn(int stage, int slot, logic signed [31:0] v);
    filter_txn_t t;
    logic [31:0] junk;
    junk     = $urandom;
    t.mode   = cfiir_pkg::MODE_COEF;
    t.sample = junk[SAMPLE_W-1:0];
    t.stage  = stage[cfiir_pkg::STAGE_SEL_W-1:0];
    t.slot   = slot[cfiir_pkg::COEF_SEL_W-1:0];
    t.coeff  = v;
    return t;
  endfunction

  task automatic send_txn(input filter_txn_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= t.mode;
    in_ch.sample_in    <= t.sample;
    in_ch.stage_select <= t.stage;
    in_ch.coeff_select <= t.slot;
    in_ch.coeff_value  <= t.coeff;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_accepted(t);
    if (t.mode == cfiir_pkg::MODE_SAMPLE)
      samples_sent++;
    else if (t.slot < cfiir_pkg::NCOEF)
      coef_writes++;
  endtask

  // Coefficient writes finish silently, so the pipeline gets its full latency
  // on top of the last result before anything is reconfigured.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input logic signed [31:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_gain(g);
    gain_writes++;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_output(out_ch.sample_out, out_ch.clipped);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int                 phase;
    int                 burst;
    int                 slot;
    bit                 feedback;
    coef_style_e        style;
    logic [31:0]        r;
    logic signed [31:0] v;
    logic signed [SAMPLE_W-1:0] s;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= cfiir_pkg::MODE_SAMPLE;
    in_ch.sample_in    <= '0;
    in_ch.stage_select <= '0;
    in_ch.coeff_select <= '0;
    in_ch.coeff_value  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All coefficients are zero after reset, so full-scale input gives silence.
    send_txn(sample_txn(SAMPLE_MAX));
    send_txn(sample_txn(SAMPLE_MIN));
    // Unity b0 everywhere turns the cascade into a straight wire.
    for (int k = 0; k < STAGES; k++)
      send_txn(coeff_txn(k, cfiir_pkg::SLOT_B0, ONE_Q27));
    // Slots past b4 do not exist and must leave the filter untouched.
    send_txn(coeff_txn(0, cfiir_pkg::NCOEF, $urandom));
    send_txn(coeff_txn(STAGES - 1, (1 << cfiir_pkg::COEF_SEL_W) - 1, COEF_MAX));
    send_txn(sample_txn(SAMPLE_MAX));
    send_txn(sample_txn(SAMPLE_MIN));
    send_txn(sample_txn('0));
    send_txn(sample_txn(1));
    send_txn(sample_txn(-1));
    // Maximum b0 overdrives the output; a1 at its negative limit then makes the
    // first stage grow until its delay word saturates.
    send_txn(coeff_txn(0, cfiir_pkg::SLOT_B0, COEF_MAX));
    send_txn(sample_txn(SAMPLE_MAX));
    send_txn(coeff_txn(0, SLOT_A1, COEF_MIN));
    repeat (6) send_txn(sample_txn(SAMPLE_MAX));

    phase = 0;
    while (samples_sent + coef_writes < ITEM_TARGET || phase < MIN_PHASES) begin
      drain_pipeline();
      if (phase % 8 == 6)
        v = $urandom;
      else
        v = gain_table[phase % 8];
      write_gain(v);
      send_idle_pct  = send_idle_tbl[phase % 4];
      recv_stall_pct = recv_stall_tbl[phase % 4];

      style = coef_style_e'(phase % 3);
      for (int st = 0; st < STAGES; st++) begin
        for (int k = 0; k < cfiir_pkg::NCOEF; k++) begin
          feedback = (k < cfiir_pkg::SLOT_B0);
          case (style)
            STYLE_HOT_FEEDFORWARD: v = feedback ? rand_sym(A_GENTLE) : $signed($urandom);
            STYLE_WILD_FEEDBACK:   v = feedback ? rand_sym(ONE_Q27) : rand_sym(B_GENTLE);
            default:               v = feedback ? rand_sym(A_GENTLE) : rand_sym(B_GENTLE);
          endcase
          send_txn(coeff_txn(st, k, v));
        end
      end

      burst = $urandom_range(90, 130);
      repeat (burst) begin
        if ($urandom_range(11) == 0) begin
          slot = $urandom_range((1 << cfiir_pkg::COEF_SEL_W) - 1);
          v = (slot < cfiir_pkg::NCOEF) ? rand_sym(A_GENTLE) : $signed($urandom);
          send_txn(coeff_txn($urandom_range(STAGES - 1), slot, v));
        end
        r = $urandom;
        case ($urandom_range(9))
          0:       s = SAMPLE_MAX;
          1:       s = SAMPLE_MIN;
          2:       s = {{(SAMPLE_W-8){r[7]}}, r[7:0]};
          default: s = r[SAMPLE_W-1:0];
        endcase
        send_txn(sample_txn(s));
      end
      phase++;
    end

    drain_pipeline();
    $display("Checked %0d output samples (%0d clipped) from %0d coefficient writes,",
             sb.outputs_seen, sb.clipped_seen, coef_writes);
    $display("%0d gain settings and %0d phases of input and output stalls; %0d mismatches.",
             gain_writes, phase, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
